// ----- rtl/core/gga_pkg.sv -----
// ----------------------------------------------------------------------------
// gga_pkg
// Shared types and character constants of the GGA sentence parser.
// ----------------------------------------------------------------------------
package gga_pkg;

    localparam logic [7:0] CHR_CR     = 8'h0D;
    localparam logic [7:0] CHR_LF     = 8'h0A;
    localparam logic [7:0] CHR_DOLLAR = 8'h24;
    localparam logic [7:0] CHR_COMMA  = 8'h2C;
    localparam logic [7:0] CHR_POINT  = 8'h2E;
    localparam logic [7:0] CHR_ZERO   = 8'h30;
    localparam logic [7:0] CHR_NINE   = 8'h39;
    localparam logic [7:0] CHR_N_UC   = 8'h4E;
    localparam logic [7:0] CHR_N_LC   = 8'h6E;
    localparam logic [7:0] CHR_E_UC   = 8'h45;
    localparam logic [7:0] CHR_E_LC   = 8'h65;

    typedef enum logic [13:0] {
        PH_HUNT = 14'h0001,
        PH_C0   = 14'h0002,
        PH_H    = 14'h0004,
        PH_M    = 14'h0008,
        PH_S    = 14'h0010,
        PH_LD   = 14'h0020,
        PH_LM   = 14'h0040,
        PH_NS   = 14'h0080,
        PH_C3   = 14'h0100,
        PH_OD   = 14'h0200,
        PH_OM   = 14'h0400,
        PH_EW   = 14'h0800,
        PH_C5   = 14'h1000,
        PH_FIX  = 14'h2000
    } t_phase;

    typedef struct packed {
        logic [7:0] rx_byte;
    } t_rx_beat;

    typedef struct packed {
        logic [6:0]  utc_hours;
        logic [6:0]  utc_minutes;
        logic [16:0] utc_millis;
        logic [6:0]  lat_degrees;
        logic [23:0] lat_min_e5;
        logic        is_north;
        logic [9:0]  lon_degrees;
        logic [23:0] lon_min_e5;
        logic        is_east;
        logic        fix_ok;
    } t_pos_beat;

    typedef struct packed {
        t_phase      phase;
        logic [2:0]  prefix_pos;
        logic [2:0]  digit_count;
        logic        after_point;
        logic        any_digit;
        logic [23:0] accum;
        logic        stopped;
        logic        cr_seen;
        t_pos_beat   held;
    } t_dec_state;

endpackage

// ----- rtl/core/gga_stream_if.sv -----
// ----------------------------------------------------------------------------
// gga_stream_if
// Valid/ready stream channel carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
interface gga_stream_if #(
    parameter type t_payload = logic [7:0]
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );
endinterface

// ----- rtl/core/gga_decode.sv -----
// ----------------------------------------------------------------------------
// gga_decode
// Next-state logic of the parser: applies one received byte to the decoder
// state and flags when the byte closes a sentence.
// ----------------------------------------------------------------------------
module gga_decode (
    input  gga_pkg::t_dec_state i_state,
    input  logic [7:0]          i_byte,
    output gga_pkg::t_dec_state o_state,
    output logic                o_emit
);
    import gga_pkg::*;

    localparam logic [2:0]  MARK_LEN     = 3'd6;
    localparam logic [2:0]  INT_LEN      = 3'd2;
    localparam logic [2:0]  LON_LEN      = 3'd3;
    localparam logic [2:0]  SEC_PLACES   = 3'd3;
    localparam logic [2:0]  MIN_PLACES   = 3'd5;
    localparam logic [23:0] INT_PART_MAX = 24'd99;

    function automatic t_phase phase_succ(input t_phase p);
        case (p)
            PH_C0:   phase_succ = PH_H;
            PH_H:    phase_succ = PH_M;
            PH_M:    phase_succ = PH_S;
            PH_S:    phase_succ = PH_LD;
            PH_LD:   phase_succ = PH_LM;
            PH_LM:   phase_succ = PH_NS;
            PH_C3:   phase_succ = PH_OD;
            PH_OD:   phase_succ = PH_OM;
            PH_OM:   phase_succ = PH_EW;
            PH_C5:   phase_succ = PH_FIX;
            default: phase_succ = p;
        endcase
    endfunction

    function automatic logic [7:0] mark_char(input logic [2:0] idx);
        case (idx)
            3'd0:    mark_char = CHR_DOLLAR;
            3'd1:    mark_char = 8'h47;
            3'd2:    mark_char = 8'h50;
            3'd3:    mark_char = 8'h47;
            3'd4:    mark_char = 8'h47;
            3'd5:    mark_char = 8'h41;
            default: mark_char = 8'h00;
        endcase
    endfunction

    function automatic t_pos_beat put_num(input t_pos_beat h, input t_phase p,
                                          input logic [23:0] v);
        t_pos_beat r;
        r = h;
        case (p)
            PH_H:    r.utc_hours   = v[6:0];
            PH_M:    r.utc_minutes = v[6:0];
            PH_S:    r.utc_millis  = v[16:0];
            PH_LD:   r.lat_degrees = v[6:0];
            PH_LM:   r.lat_min_e5  = v;
            PH_OD:   r.lon_degrees = v[9:0];
            PH_OM:   r.lon_min_e5  = v;
            default: r = h;
        endcase
        return r;
    endfunction

    function automatic t_dec_state clear_num(input t_dec_state s);
        t_dec_state r;
        r             = s;
        r.digit_count = '0;
        r.after_point = 1'b0;
        r.any_digit   = 1'b0;
        r.accum       = '0;
        return r;
    endfunction

    logic        is_digit;
    logic [23:0] digit_ext;
    logic [23:0] acc10;
    logic [23:0] acc_sat;
    logic [2:0]  field_len;
    logic [2:0]  frac_places;
    logic [2:0]  scale_exp;
    logic [23:0] scaled;

    assign is_digit    = i_byte inside {[CHR_ZERO:CHR_NINE]};
    assign digit_ext   = {20'd0, i_byte[3:0]};
    assign acc10       = (i_state.accum << 3) + (i_state.accum << 1) + digit_ext;
    assign acc_sat     = (acc10 > INT_PART_MAX) ? INT_PART_MAX : acc10;
    assign field_len   = (i_state.phase == PH_OD) ? LON_LEN : INT_LEN;
    assign frac_places = (i_state.phase == PH_S) ? SEC_PLACES : MIN_PLACES;
    assign scale_exp   = frac_places - i_state.digit_count;

    always_comb begin
        case (scale_exp)
            3'd0:    scaled = i_state.accum;
            3'd1:    scaled = i_state.accum * 24'd10;
            3'd2:    scaled = i_state.accum * 24'd100;
            3'd3:    scaled = i_state.accum * 24'd1000;
            3'd4:    scaled = i_state.accum * 24'd10000;
            3'd5:    scaled = i_state.accum * 24'd100000;
            default: scaled = i_state.accum;
        endcase
    end

    always_comb begin
        o_state = i_state;
        o_emit  = 1'b0;
        if (i_byte == CHR_LF && i_state.cr_seen) begin
            o_emit             = (i_state.phase != PH_HUNT);
            o_state.cr_seen    = 1'b0;
            o_state.phase      = PH_HUNT;
            o_state.prefix_pos = '0;
            o_state.stopped    = 1'b0;
            o_state            = clear_num(o_state);
        end else begin
            o_state.cr_seen = (i_byte == CHR_CR);
            if (i_byte == CHR_DOLLAR) begin
                o_state.phase      = PH_HUNT;
                o_state.prefix_pos = 3'd1;
                o_state.stopped    = 1'b0;
                o_state            = clear_num(o_state);
            end else if (i_state.phase == PH_HUNT) begin
                if (i_state.prefix_pos != 3'd0 && i_state.prefix_pos < MARK_LEN &&
                    i_byte == mark_char(i_state.prefix_pos)) begin
                    if (i_state.prefix_pos == MARK_LEN - 3'd1) begin
                        o_state.prefix_pos    = '0;
                        o_state.phase         = PH_C0;
                        o_state.stopped       = 1'b0;
                        o_state               = clear_num(o_state);
                        o_state.held.is_north = 1'b0;
                        o_state.held.is_east  = 1'b0;
                        o_state.held.fix_ok   = 1'b0;
                    end else begin
                        o_state.prefix_pos = i_state.prefix_pos + 3'd1;
                    end
                end else begin
                    o_state.prefix_pos = '0;
                end
            end else if (!i_state.stopped) begin
                case (i_state.phase)
                    PH_C0, PH_C3, PH_C5: begin
                        if (i_byte == CHR_COMMA) begin
                            o_state.phase = phase_succ(i_state.phase);
                            o_state       = clear_num(o_state);
                        end else begin
                            o_state.stopped = 1'b1;
                        end
                    end
                    PH_H, PH_M, PH_LD, PH_OD: begin
                        if (is_digit) begin
                            o_state.accum       = acc10;
                            o_state.digit_count = i_state.digit_count + 3'd1;
                            if (i_state.digit_count + 3'd1 >= field_len) begin
                                o_state.held  = put_num(i_state.held, i_state.phase, acc10);
                                o_state.phase = phase_succ(i_state.phase);
                                o_state       = clear_num(o_state);
                            end
                        end else if (i_state.digit_count != 3'd0) begin
                            // short field: close it, then the byte opens the next one
                            o_state.held  = put_num(i_state.held, i_state.phase,
                                                    i_state.accum);
                            o_state.phase = phase_succ(i_state.phase);
                            o_state       = clear_num(o_state);
                            if (i_state.phase == PH_H) begin
                                o_state.stopped = 1'b1;
                            end else if (i_byte == CHR_POINT) begin
                                o_state.after_point = 1'b1;
                            end else begin
                                o_state.stopped = 1'b1;
                            end
                        end else begin
                            o_state.stopped = 1'b1;
                        end
                    end
                    PH_S, PH_LM, PH_OM: begin
                        if (is_digit) begin
                            o_state.any_digit = 1'b1;
                            if (!i_state.after_point) begin
                                o_state.accum = acc_sat;
                            end else if (i_state.digit_count < frac_places) begin
                                o_state.accum       = acc10;
                                o_state.digit_count = i_state.digit_count + 3'd1;
                            end
                        end else if (i_byte == CHR_POINT && !i_state.after_point) begin
                            o_state.after_point = 1'b1;
                        end else if (!i_state.any_digit) begin
                            o_state.stopped = 1'b1;
                        end else begin
                            o_state.held = put_num(i_state.held, i_state.phase, scaled);
                            if (i_byte == CHR_COMMA) begin
                                o_state.phase = phase_succ(i_state.phase);
                                o_state       = clear_num(o_state);
                            end else begin
                                o_state.stopped = 1'b1;
                            end
                        end
                    end
                    PH_NS: begin
                        o_state.held.is_north = (i_byte == CHR_N_UC) || (i_byte == CHR_N_LC);
                        o_state.phase         = PH_C3;
                    end
                    PH_EW: begin
                        o_state.held.is_east = (i_byte == CHR_E_UC) || (i_byte == CHR_E_LC);
                        o_state.phase        = PH_C5;
                    end
                    PH_FIX: begin
                        if (is_digit) begin
                            if (i_byte != CHR_ZERO) begin
                                o_state.held.fix_ok = 1'b1;
                            end
                        end else begin
                            o_state.stopped = 1'b1;
                        end
                    end
                    default: begin
                        o_state.stopped = 1'b1;
                    end
                endcase
            end
        end
    end

endmodule

// ----- rtl/core/nmea_gga_sentence_parser.sv -----
// ----------------------------------------------------------------------------
// nmea_gga_sentence_parser
// Streaming decoder of $GPGGA sentences: time, latitude, longitude, fix.
// ----------------------------------------------------------------------------
// Takes one serial byte per beat on i_rx and emits one position beat on o_pos
// for each CR LF that closes a $GPGGA sentence. A byte can be taken on every
// cycle while the input does not stall: it is registered in the input
// register, then the next-state decode (one multiply-by-ten accumulate and one
// constant scaling per byte) updates the decoder state and loads the output
// register as the byte leaves the input register. The input stalls only while
// a result waits in the output register and the pending byte would produce
// another one.
module nmea_gga_sentence_parser (
    input  logic         i_clk,
    input  logic         i_rst_n,
    gga_stream_if.sink   i_rx,
    gga_stream_if.source o_pos
);
    import gga_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    t_dec_state r_state;
    t_dec_state w_next;
    logic       w_emit;
    logic       w_adv;
    logic       r_out_valid;
    t_pos_beat  r_out;

    gga_decode u_decode (
        .i_state (r_state),
        .i_byte  (r_in_byte),
        .o_state (w_next),
        .o_emit  (w_emit)
    );

    assign w_adv         = r_in_valid && (!w_emit || !r_out_valid || o_pos.ready);
    assign i_rx.ready    = !r_in_valid || w_adv;
    assign o_pos.valid   = r_out_valid;
    assign o_pos.payload = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid          <= 1'b0;
            r_out_valid         <= 1'b0;
            r_state.phase       <= PH_HUNT;
            r_state.prefix_pos  <= '0;
            r_state.digit_count <= '0;
            r_state.after_point <= 1'b0;
            r_state.any_digit   <= 1'b0;
            r_state.accum       <= '0;
            r_state.stopped     <= 1'b0;
            r_state.cr_seen     <= 1'b0;
            r_state.held        <= '0;
        end else begin
            if (i_rx.ready) begin
                r_in_valid <= i_rx.valid;
            end
            if (w_adv) begin
                r_state <= w_next;
            end
            if (w_adv && w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_pos.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.payload.rx_byte;
        end
        if (w_adv && w_emit) begin
            r_out <= r_state.held;
        end
    end

endmodule

// ----- dv/tb_nmea_gga_sentence_parser.sv -----
// ----------------------------------------------------------------------------
// tb_nmea_gga_sentence_parser
// Self-checking bench for the streaming $GPGGA decoder.
// ----------------------------------------------------------------------------
// The bench feeds serial bytes on the rx channel in bursts with random gaps.
// A first table of sentences covers field extremes and the awkward corners:
// empty or short fields, doubled points, '$' restarts, CR and LF inside
// fields, partial prefixes. Random well-formed sentences then follow, mixed
// with corrupted, truncated and noise lines. A byte-level decoder in the bench
// predicts each position beat where no table row gives it, and every beat on
// o_pos is checked field by field. The sink stalls on its own pattern and holds
// off twice for long stretches so that the parser backs up.
// ----------------------------------------------------------------------------
module tb_nmea_gga_sentence_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import gga_pkg::*;

    localparam int    CLK_PERIOD     = 10;
    localparam int    RESET_CYCLES   = 11;
    localparam int    RANDOM_BYTES   = 500;
    localparam int    HOLD_CYCLES    = 300;
    localparam int    WATCHDOG_LIMIT = 3000;
    localparam string SENTENCE_TAG   = "$GPGGA";

    localparam t_pos_beat POS_ZERO = '0;
    localparam t_pos_beat POS_MAX  = '{
        utc_hours: 7'd99, utc_minutes: 7'd99, utc_millis: 17'd99999,
        lat_degrees: 7'd99, lat_min_e5: 24'd9999999, is_north: 1'b1,
        lon_degrees: 10'd999, lon_min_e5: 24'd9999999, is_east: 1'b1,
        fix_ok: 1'b1};

    typedef enum int {
        RDY_ALWAYS,
        RDY_COIN,
        RDY_ONE_IN_FOUR,
        RDY_MOSTLY
    } t_sink_mode;

    typedef struct {
        string     text;
        bit        typed;
        t_pos_beat want;
    } t_dir_row;

    logic clk = 1'b0;
    logic rst_n;

    gga_stream_if #(.t_payload(t_rx_beat))  rx_if ();
    gga_stream_if #(.t_payload(t_pos_beat)) pos_if ();

    nmea_gga_sentence_parser u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_rx    (rx_if),
        .o_pos   (pos_if)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // decoder state of the bench
    t_phase      scan_phase;
    int          tag_pos;
    int          num_digits;
    bit          seen_point;
    bit          seen_digit;
    logic [31:0] num_acc;
    bit          scan_halted;
    bit          cr_pending;
    t_pos_beat   held;

    t_pos_beat   position_queue[$];
    logic [7:0]  line_bytes[$];
    t_dir_row    dir_rows[$];

    int mismatches     = 0;
    int fixes_expected = 0;
    int fixes_checked  = 0;
    int bytes_sent     = 0;
    int lines_sent     = 0;
    int burst_left     = 0;
    int quiet_cycles   = 0;
    int holds_done     = 0;

    function automatic void clear_number();
        num_digits = 0;
        seen_point = 1'b0;
        seen_digit = 1'b0;
        num_acc    = '0;
    endfunction

    function automatic t_phase phase_after(t_phase p);
        case (p)
            PH_C0:   return PH_H;
            PH_H:    return PH_M;
            PH_M:    return PH_S;
            PH_S:    return PH_LD;
            PH_LD:   return PH_LM;
            PH_LM:   return PH_NS;
            PH_NS:   return PH_C3;
            PH_C3:   return PH_OD;
            PH_OD:   return PH_OM;
            PH_OM:   return PH_EW;
            PH_EW:   return PH_C5;
            PH_C5:   return PH_FIX;
            default: return PH_HUNT;
        endcase
    endfunction

    // integer width, or number of fraction digits kept
    function automatic int field_digits(t_phase p);
        case (p)
            PH_OD, PH_S:  return 3;
            PH_LM, PH_OM: return 5;
            default:      return 2;
        endcase
    endfunction

    function automatic logic [31:0] scale_up(logic [31:0] v, int n);
        for (int k = 0; k < n; k++) v = v * 10;
        return v;
    endfunction

    function automatic void next_field();
        scan_phase = phase_after(scan_phase);
        clear_number();
    endfunction

    function automatic void store_field(logic [31:0] v);
        case (scan_phase)
            PH_H:    held.utc_hours   = v[6:0];
            PH_M:    held.utc_minutes = v[6:0];
            PH_S:    held.utc_millis  = v[16:0];
            PH_LD:   held.lat_degrees = v[6:0];
            PH_LM:   held.lat_min_e5  = v[23:0];
            PH_OD:   held.lon_degrees = v[9:0];
            PH_OM:   held.lon_min_e5  = v[23:0];
            default: ;
        endcase
    endfunction

    function automatic void scan_field_byte(logic [7:0] c);
        bit          again;
        int          guard;
        bit          is_digit;
        logic [31:0] digit;
        again    = 1'b1;
        guard    = 0;
        is_digit = (c >= CHR_ZERO) && (c <= CHR_NINE);
        digit    = 32'(c - CHR_ZERO);
        while (again && !scan_halted && guard < 4) begin
            again = 1'b0;
            guard++;
            case (scan_phase)
                PH_C0, PH_C3, PH_C5: begin
                    if (c == CHR_COMMA) next_field();
                    else scan_halted = 1'b1;
                end
                PH_H, PH_M, PH_LD, PH_OD: begin
                    if (is_digit) begin
                        num_acc = num_acc * 10 + digit;
                        num_digits++;
                        if (num_digits >= field_digits(scan_phase)) begin
                            store_field(num_acc);
                            next_field();
                        end
                    end else if (num_digits > 0) begin
                        // short field: the terminator goes on to the next field
                        store_field(num_acc);
                        next_field();
                        again = 1'b1;
                    end else begin
                        scan_halted = 1'b1;
                    end
                end
                PH_S, PH_LM, PH_OM: begin
                    if (is_digit) begin
                        seen_digit = 1'b1;
                        if (!seen_point) begin
                            num_acc = num_acc * 10 + digit;
                            if (num_acc > 99) num_acc = 99;
                        end else if (num_digits < field_digits(scan_phase)) begin
                            num_acc = num_acc * 10 + digit;
                            num_digits++;
                        end
                    end else if (c == CHR_POINT && !seen_point) begin
                        seen_point = 1'b1;
                    end else if (!seen_digit) begin
                        scan_halted = 1'b1;
                    end else begin
                        store_field(scale_up(num_acc, field_digits(scan_phase) - num_digits));
                        if (c == CHR_COMMA) next_field();
                        else scan_halted = 1'b1;
                    end
                end
                PH_NS: begin
                    held.is_north = (c == CHR_N_UC) || (c == CHR_N_LC);
                    scan_phase    = PH_C3;
                end
                PH_EW: begin
                    held.is_east = (c == CHR_E_UC) || (c == CHR_E_LC);
                    scan_phase   = PH_C5;
                end
                PH_FIX: begin
                    if (is_digit) begin
                        if (c != CHR_ZERO) held.fix_ok = 1'b1;
                    end else begin
                        scan_halted = 1'b1;
                    end
                end
                default: scan_halted = 1'b1;
            endcase
        end
    endfunction

    function automatic void predict_byte(logic [7:0] c, output bit fired,
                                         output t_pos_beat res);
        fired = 1'b0;
        res   = '0;
        if (c == CHR_LF && cr_pending) begin
            if (scan_phase != PH_HUNT) begin
                fired = 1'b1;
                res   = held;
            end
            cr_pending  = 1'b0;
            scan_phase  = PH_HUNT;
            tag_pos     = 0;
            scan_halted = 1'b0;
            clear_number();
        end else begin
            cr_pending = (c == CHR_CR);
            if (c == CHR_DOLLAR) begin
                scan_phase  = PH_HUNT;
                tag_pos     = 1;
                scan_halted = 1'b0;
                clear_number();
            end else if (scan_phase == PH_HUNT) begin
                if (tag_pos > 0 && tag_pos < 6 && c == SENTENCE_TAG[tag_pos]) begin
                    tag_pos++;
                    if (tag_pos == 6) begin
                        tag_pos       = 0;
                        scan_phase    = PH_C0;
                        scan_halted   = 1'b0;
                        clear_number();
                        held.is_north = 1'b0;
                        held.is_east  = 1'b0;
                        held.fix_ok   = 1'b0;
                    end
                end else begin
                    tag_pos = 0;
                end
            end else begin
                scan_field_byte(c);
            end
        end
    endfunction

    function automatic void add_row(string text, bit typed = 1'b0, t_pos_beat want = '0);
        t_dir_row row;
        row.text  = text;
        row.typed = typed;
        row.want  = want;
        dir_rows.push_back(row);
    endfunction

    function automatic void push_text(string s);
        for (int k = 0; k < s.len(); k++) line_bytes.push_back(s[k]);
    endfunction

    function automatic void push_digits(int n);
        for (int k = 0; k < n; k++) line_bytes.push_back(CHR_ZERO + 8'($urandom_range(0, 9)));
    endfunction

    // mostly the full width, now and then shorter or empty
    function automatic int field_len(int n);
        return ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, n)) : n;
    endfunction

    function automatic void push_minutes();
        push_digits(field_len(2));
        if ($urandom_range(0, 4) != 0) begin
            line_bytes.push_back(CHR_POINT);
            push_digits($urandom_range(0, 7));
        end
        line_bytes.push_back(CHR_COMMA);
    endfunction

    function automatic void push_hemisphere(string letters);
        if ($urandom_range(0, 9) == 0) line_bytes.push_back(8'($urandom_range(0, 255)));
        else line_bytes.push_back(letters[$urandom_range(0, 3)]);
        line_bytes.push_back(CHR_COMMA);
    endfunction

    function automatic void build_gga_line();
        push_text("$GPGGA,");
        push_digits(field_len(2));
        push_digits(field_len(2));
        push_digits($urandom_range(0, 3));
        if ($urandom_range(0, 3) != 0) begin
            line_bytes.push_back(CHR_POINT);
            push_digits($urandom_range(0, 5));
        end
        line_bytes.push_back(CHR_COMMA);
        push_digits(field_len(2));
        push_minutes();
        push_hemisphere("NSns");
        push_digits(field_len(3));
        push_minutes();
        push_hemisphere("EWew");
        push_digits($urandom_range(1, 2));
        if ($urandom_range(0, 1) != 0) push_text(",08,0.9,545.4,M,46.9,M,,*47");
        case ($urandom_range(0, 19))
            0:       line_bytes.push_back(CHR_CR);
            1:       line_bytes.push_back(CHR_LF);
            2:       ;
            default: push_text("\015\n");
        endcase
    endfunction

    function automatic void build_random_line();
        int cut;
        case ($urandom_range(0, 9))
            0: begin
                repeat ($urandom_range(3, 30)) line_bytes.push_back(8'($urandom_range(0, 255)));
                if ($urandom_range(0, 1) != 0) push_text("\015\n");
            end
            1: begin
                build_gga_line();
                line_bytes[$urandom_range(0, line_bytes.size() - 1)] = 8'($urandom_range(0, 255));
            end
            2: begin
                build_gga_line();
                cut = $urandom_range(1, line_bytes.size() - 1);
                line_bytes = line_bytes[0:cut - 1];
                push_text("\015\n");
            end
            3: begin
                build_gga_line();
                line_bytes.insert($urandom_range(1, line_bytes.size() - 1), CHR_DOLLAR);
            end
            default: build_gga_line();
        endcase
    endfunction

    // offer each byte of the line; predict on acceptance
    task automatic send_line(input bit typed, input t_pos_beat want);
        bit        fired;
        t_pos_beat got;
        int        gap;
        foreach (line_bytes[k]) begin
            @(negedge clk);
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 40);
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0) begin
                    rx_if.valid <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            burst_left--;
            rx_if.valid   <= 1'b1;
            rx_if.payload <= '{rx_byte: line_bytes[k]};
            @(posedge clk);
            while (!rx_if.ready) @(posedge clk);
            predict_byte(line_bytes[k], fired, got);
            if (fired) begin
                position_queue.push_back(typed ? want : got);
                fixes_expected++;
            end
            bytes_sent++;
        end
        line_bytes.delete();
        lines_sent++;
    endtask

    task automatic check_field(input string name, input logic [31:0] expv,
                               input logic [31:0] gotv);
        if (expv !== gotv) begin
            $display("%0t: %s expected %0d got %0d", $time, name, expv, gotv);
            mismatches++;
        end
    endtask

    always @(posedge clk) begin
        t_pos_beat want;
        t_pos_beat seen;
        if (rst_n && pos_if.valid && pos_if.ready) begin
            seen = pos_if.payload;
            if (position_queue.size() == 0) begin
                $display("%0t: position beat with none expected, hours %0d minutes %0d",
                         $time, seen.utc_hours, seen.utc_minutes);
                mismatches++;
            end else begin
                want = position_queue.pop_front();
                fixes_checked++;
                check_field("utc_hours",   32'(want.utc_hours),   32'(seen.utc_hours));
                check_field("utc_minutes", 32'(want.utc_minutes), 32'(seen.utc_minutes));
                check_field("utc_millis",  32'(want.utc_millis),  32'(seen.utc_millis));
                check_field("lat_degrees", 32'(want.lat_degrees), 32'(seen.lat_degrees));
                check_field("lat_min_e5",  32'(want.lat_min_e5),  32'(seen.lat_min_e5));
                check_field("is_north",    32'(want.is_north),    32'(seen.is_north));
                check_field("lon_degrees", 32'(want.lon_degrees), 32'(seen.lon_degrees));
                check_field("lon_min_e5",  32'(want.lon_min_e5),  32'(seen.lon_min_e5));
                check_field("is_east",     32'(want.is_east),     32'(seen.is_east));
                check_field("fix_ok",      32'(want.fix_ok),      32'(seen.fix_ok));
            end
        end
    end

    // sink: own stall pattern, plus two long hold-offs
    initial begin
        t_sink_mode mode;
        int         mode_left;
        int         tick;
        pos_if.ready = 1'b0;
        mode         = RDY_ALWAYS;
        mode_left    = 0;
        tick         = 0;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            tick++;
            if (holds_done < 2 && fixes_checked >= 8 + 10 * holds_done) begin
                holds_done++;
                pos_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            if (mode_left == 0) begin
                mode      = t_sink_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (mode)
                RDY_ALWAYS:      pos_if.ready <= 1'b1;
                RDY_COIN:        pos_if.ready <= 1'($urandom_range(0, 1));
                RDY_ONE_IN_FOUR: pos_if.ready <= (tick % 4 == 0);
                default:         pos_if.ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (rx_if.valid && rx_if.ready) || (pos_if.valid && pos_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no beat for %0d cycles, %0d beats outstanding",
                     $time, quiet_cycles, position_queue.size());
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int directed_fixes;
        int random_bytes;
        rst_n         = 1'b0;
        rx_if.valid   = 1'b0;
        rx_if.payload = '0;
        scan_phase    = PH_HUNT;
        tag_pos       = 0;
        scan_halted   = 1'b0;
        cr_pending    = 1'b0;
        held          = '0;
        clear_number();

        add_row("$GPGGA,\015\n", 1'b1, POS_ZERO);
        add_row("$GPGGA,999999.999,9999.99999,N,99999.99999,E,9\015\n", 1'b1, POS_MAX);
        add_row("$GPGGA,000000.000,0000.00000,S,00000.00000,W,0\015\n", 1'b1, POS_ZERO);
        add_row("$GPGGA,123519.25,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,*47\015\n");
        add_row("$GPGGA,010203,0102.5,n,00304.75,e,2\015\n");
        add_row("$GPGGA,0102.5,4.25,x,7.5,W,03\015\n");
        add_row("$GPGGA,1200123.4567,0299.999999,N,1234.5,E,1\015\n");
        add_row("$GPGGA,,,,,,,\015\n");
        add_row("$GPGGA,7,,\015\n");
        add_row("$GPGGA,0102.,4807.0,N,1,E,1\015\n");
        add_row("$GPGGA,01021.2.3,\015\n");
        add_row("$GPGGA,0102$GPGGA,0304,\015\n");
        add_row("$GPGGA,010203,0102.5,$GPGGA,0506,\015\n");
        add_row("$GPGGA,010203,0102.5,\015,00304.75,\n,5\015\n");
        add_row("$GPGGA,010203,0102.5,N\015\n");
        add_row("$GPGGA,010203,0102.5,\015\n");
        add_row("$GPGGA,0102\015\015\n");
        add_row("$GPGGA,01\n02\015\n");
        add_row("\015\n$GPGG\015\nGPGGA,1\015\n$GPGSA,1,2\015\n");
        add_row("$$GPGGA,11\015\nG$GPGGA,2233\015\n");
        add_row("$GPGGA\015\n");
        add_row("$GPGGA,010203,0102.5,N,00304.75,E,0,\015\n");
        add_row("$GPGGA,2359,\015\n");

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[r]) begin
            push_text(dir_rows[r].text);
            send_line(dir_rows[r].typed, dir_rows[r].want);
        end
        directed_fixes = fixes_expected;

        random_bytes = 0;
        while (random_bytes < RANDOM_BYTES) begin
            build_random_line();
            random_bytes += line_bytes.size();
            send_line(1'b0, POS_ZERO);
        end
        @(negedge clk);
        rx_if.valid <= 1'b0;

        while (position_queue.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Run covered %0d bytes in %0d lines (%0d table rows, %0d random bytes)",
                 bytes_sent, lines_sent, dir_rows.size(), random_bytes);
        $display("Position beats checked: %0d, %0d from the table; long sink hold-offs: %0d",
                 fixes_checked, directed_fixes, holds_done);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
